/* rtl/esv_pkg.sv */
package esv_pkg;

	localparam int unsigned MaxStreamBytes = 536870912;
	localparam int unsigned FixedBytes     = 36;
	localparam int unsigned EditBytes      = 17;
	localparam int unsigned QueueDepth     = 4;

	localparam logic [63:0] FnvBasis = 64'd1469598103934665603;
	localparam logic [31:0] FormatVersion = 32'd1;

	typedef enum logic [3:0] {
		ST_OK        = 4'd0,
		ST_SIZE      = 4'd1,
		ST_SIGNATURE = 4'd2,
		ST_VERSION   = 4'd3,
		ST_WORLD     = 4'd4,
		ST_COUNT     = 4'd5,
		ST_BLOCK     = 4'd6,
		ST_ORDER     = 4'd7,
		ST_CHECKSUM  = 4'd8
	} status_t;

	typedef enum logic {
		OP_START = 1'b0,
		OP_BYTE  = 1'b1
	} opcode_t;

	typedef enum logic {
		KIND_EDIT   = 1'b0,
		KIND_STATUS = 1'b1
	} kind_t;

	// One classified input word as it sits in the queue.
	typedef struct packed {
		logic        is_start;
		logic        len_bad;
		logic [31:0] length;
		logic [7:0]  data;
	} item_t;

	// Signature bytes "PROJ4DWS", first byte at index 0.
	function automatic logic [7:0] sig_byte(input logic [2:0] idx);
		logic [7:0] r;
		case (idx)
			3'd0: r = 8'h50;
			3'd1: r = 8'h52;
			3'd2: r = 8'h4F;
			3'd3: r = 8'h4A;
			3'd4: r = 8'h34;
			3'd5: r = 8'h44;
			3'd6: r = 8'h57;
			default: r = 8'h53;
		endcase
		return r;
	endfunction

	// FNV-1a step; the prime is 2^40 + 0x1B3, so the multiply is shifted adds.
	function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b);
		logic [63:0] x;
		x = h ^ {56'd0, b};
		return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
	endfunction

endpackage

/* rtl/esv_front.sv */
module esv_front import esv_pkg::*; #(
	parameter int unsigned MAX_STREAM_BYTES = MaxStreamBytes
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,
	input  logic        s_tuser,
	output logic        q_valid,
	output item_t       q_item,
	input  logic        q_pop
);

	localparam int PtrW = $clog2(QueueDepth);

	item_t             mem_q [QueueDepth];
	logic [PtrW-1:0]   wr_ptr_q;
	logic [PtrW-1:0]   rd_ptr_q;
	logic [PtrW:0]     count_q;
	item_t             in_item;
	logic              push;

	always_comb begin
		in_item.is_start = (s_tuser == OP_START);
		in_item.length   = s_tdata[31:0];
		in_item.data     = s_tdata[39:32];
		in_item.len_bad  = (s_tdata[31:0] < 32'(FixedBytes)) ||
		                   (s_tdata[31:0] > 32'(MAX_STREAM_BYTES));
	end

	assign s_tready = (count_q != (PtrW+1)'(QueueDepth));
	assign push     = s_tvalid && s_tready;
	assign q_valid  = (count_q != '0);
	assign q_item   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (q_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, q_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* rtl/esv_back.sv */
module esv_back import esv_pkg::*; #(
	parameter int unsigned MAX_STREAM_BYTES = MaxStreamBytes
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         q_valid,
	input  item_t        q_item,
	output logic         q_pop,
	input  logic [1:0]   expected_terrain,
	input  logic [31:0]  expected_seed,
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [135:0] m_tdata,
	output logic         m_tuser
);

	localparam logic [63:0] Limit = 64'((MAX_STREAM_BYTES - FixedBytes) / EditBytes);
	localparam int EwRaw = $clog2((MAX_STREAM_BYTES - FixedBytes) / EditBytes + 1);
	localparam int Ew = (EwRaw < 1) ? 1 : EwRaw;

	typedef enum logic [3:0] {
		PH_IDLE   = 4'b0001,
		PH_HEADER = 4'b0010,
		PH_EDITS  = 4'b0100,
		PH_CHECK  = 4'b1000
	} phase_t;

	phase_t        phase_q, phase_d;
	logic [4:0]    pos_q, pos_d;
	logic [31:0]   total_q, total_d;
	logic [63:0]   hash_q, hash_d;
	logic [63:0]   shift_q, shift_d;
	logic [31:0]   ver_q, ver_d;
	logic [31:0]   terr_q, terr_d;
	logic [31:0]   seed_q, seed_d;
	logic [Ew-1:0] left_q, left_d;
	logic [31:0]   cur_q [4];
	logic [31:0]   cur_d [4];
	logic [31:0]   prev_q [4];
	logic          prev_valid_q, prev_valid_d;
	logic          upd_prev;

	logic          emit;
	kind_t         emit_kind;
	status_t       emit_status;

	logic          out_valid_q;
	kind_t         out_kind_q;
	logic [31:0]   out_coord_q [4];
	logic          out_solid_q;
	status_t       out_status_q;

	logic [7:0]    b;
	logic [4:0]    cnt_off;
	logic [31:0]   expect_len;
	logic [3:0]    lt, gt;
	logic          increase;

	assign q_pop = q_valid && (!out_valid_q || m_tready);
	assign b     = q_item.data;

	// Per-lane signed compares, then first differing lane decides.
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			lt[i] = $signed(prev_q[i]) < $signed(cur_q[i]);
			gt[i] = $signed(prev_q[i]) > $signed(cur_q[i]);
		end
		increase = lt[0] || (!gt[0] && (lt[1] || (!gt[1] && (lt[2] ||
		           (!gt[2] && lt[3])))));
	end

	always_comb begin
		phase_d      = phase_q;
		pos_d        = pos_q;
		total_d      = total_q;
		hash_d       = hash_q;
		shift_d      = shift_q;
		ver_d        = ver_q;
		terr_d       = terr_q;
		seed_d       = seed_q;
		left_d       = left_q;
		prev_valid_d = prev_valid_q;
		upd_prev     = 1'b0;
		emit         = 1'b0;
		emit_kind    = KIND_STATUS;
		emit_status  = ST_OK;
		cnt_off      = pos_q - 5'd20;
		expect_len   = '0;
		for (int i = 0; i < 4; i++) begin
			cur_d[i] = cur_q[i];
		end

		if (q_pop) begin
			if (q_item.is_start) begin
				hash_d       = FnvBasis;
				pos_d        = '0;
				shift_d      = '0;
				ver_d        = '0;
				terr_d       = '0;
				seed_d       = '0;
				left_d       = '0;
				prev_valid_d = 1'b0;
				total_d      = q_item.length;
				if (q_item.len_bad) begin
					emit        = 1'b1;
					emit_status = ST_SIZE;
					phase_d     = PH_IDLE;
				end else begin
					phase_d = PH_HEADER;
				end
			end else begin
				unique case (phase_q)
					PH_IDLE: begin
					end
					PH_CHECK: begin
						shift_d[pos_q[2:0]*8 +: 8] = b;
						pos_d = pos_q + 5'd1;
						if (pos_q[2:0] == 3'd7) begin
							emit        = 1'b1;
							emit_status = (shift_d == hash_q) ? ST_OK : ST_CHECKSUM;
							phase_d     = PH_IDLE;
						end
					end
					PH_HEADER: begin
						hash_d = fnv_step(hash_q, b);
						pos_d  = pos_q + 5'd1;
						if (pos_q < 5'd8) begin
							if (b != sig_byte(pos_q[2:0])) begin
								emit        = 1'b1;
								emit_status = ST_SIGNATURE;
								phase_d     = PH_IDLE;
							end
						end else if (pos_q < 5'd12) begin
							ver_d[pos_q[1:0]*8 +: 8] = b;
						end else if (pos_q < 5'd16) begin
							terr_d[pos_q[1:0]*8 +: 8] = b;
						end else if (pos_q < 5'd20) begin
							seed_d[pos_q[1:0]*8 +: 8] = b;
						end else begin
							shift_d[cnt_off[2:0]*8 +: 8] = b;
						end
						if (pos_q == 5'd27) begin
							expect_len = 32'(FixedBytes) +
							             ({{(32-Ew){1'b0}}, shift_d[Ew-1:0]} << 4) +
							             {{(32-Ew){1'b0}}, shift_d[Ew-1:0]};
							if (ver_q != FormatVersion) begin
								emit        = 1'b1;
								emit_status = ST_VERSION;
								phase_d     = PH_IDLE;
							end else if (terr_q != {30'd0, expected_terrain} ||
							             seed_q != expected_seed) begin
								emit        = 1'b1;
								emit_status = ST_WORLD;
								phase_d     = PH_IDLE;
							end else if (shift_d > Limit || total_q != expect_len) begin
								emit        = 1'b1;
								emit_status = ST_COUNT;
								phase_d     = PH_IDLE;
							end else begin
								left_d  = shift_d[Ew-1:0];
								pos_d   = '0;
								shift_d = '0;
								phase_d = (left_d != '0) ? PH_EDITS : PH_CHECK;
							end
						end
					end
					PH_EDITS: begin
						hash_d = fnv_step(hash_q, b);
						if (pos_q < 5'd16) begin
							if (pos_q == 5'd0) begin
								for (int i = 0; i < 4; i++) begin
									cur_d[i] = '0;
								end
							end
							cur_d[pos_q[3:2]][pos_q[1:0]*8 +: 8] = b;
							pos_d = pos_q + 5'd1;
						end else if (b > 8'd1) begin
							emit        = 1'b1;
							emit_status = ST_BLOCK;
							phase_d     = PH_IDLE;
						end else if (prev_valid_q && !increase) begin
							emit        = 1'b1;
							emit_status = ST_ORDER;
							phase_d     = PH_IDLE;
						end else begin
							emit         = 1'b1;
							emit_kind    = KIND_EDIT;
							upd_prev     = 1'b1;
							prev_valid_d = 1'b1;
							pos_d        = '0;
							left_d       = left_q - 1'b1;
							if (left_q == Ew'(1)) begin
								phase_d = PH_CHECK;
								shift_d = '0;
							end
						end
					end
					default: begin
						phase_d = PH_IDLE;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			pos_q        <= '0;
			prev_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			phase_q      <= phase_d;
			pos_q        <= pos_d;
			prev_valid_q <= prev_valid_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		total_q <= total_d;
		hash_q  <= hash_d;
		shift_q <= shift_d;
		ver_q   <= ver_d;
		terr_q  <= terr_d;
		seed_q  <= seed_d;
		left_q  <= left_d;
		for (int i = 0; i < 4; i++) begin
			cur_q[i] <= cur_d[i];
			if (upd_prev) begin
				prev_q[i] <= cur_q[i];
			end
		end
		if (emit) begin
			out_kind_q   <= emit_kind;
			out_solid_q  <= (emit_kind == KIND_EDIT) ? b[0] : 1'b0;
			out_status_q <= emit_status;
			for (int i = 0; i < 4; i++) begin
				out_coord_q[i] <= (emit_kind == KIND_EDIT) ? cur_q[i] : 32'd0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_kind_q;
	assign m_tdata  = {3'd0, out_status_q, out_solid_q, out_coord_q[3], out_coord_q[2],
	                   out_coord_q[1], out_coord_q[0]};

endmodule

/* rtl/edit_save_stream_validator.sv */
// Save-stream validator: one word accepted per cycle while the four-word queue has room.
// The word that causes a result is written into the queue, popped by the back end, and the
// result is then registered in the output register that drives m_tvalid; queued words add their wait.
// Throughput is one word per cycle while the output register drains; a result that
// waits for m_tready holds the back end, and the four-word queue then fills.
// arst_n clears the queue, the output register and the stream state to idle;
// the world registers then hold terrain 0 and seed 0.
module edit_save_stream_validator import esv_pkg::*; #(
	parameter int unsigned MAX_STREAM_BYTES = MaxStreamBytes
) (
	input  logic         clk,
	input  logic         arst_n,
	// APB-style world configuration port.
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready,
	// Input words.
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [39:0]  s_tdata,  // stream_length[31:0], data_byte[39:32]
	input  logic         s_tuser,  // opcode
	// Result words.
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [135:0] m_tdata,  // coord_x, coord_y, coord_z, coord_w, solid, status, pad
	output logic         m_tuser   // kind
);

	// Register map: terrain at byte address 0, seed at byte address 4.
	logic [1:0]  terrain_q;
	logic [31:0] seed_q;
	logic        q_valid;
	logic        q_pop;
	item_t       q_item;

	assign pready = 1'b1;
	assign prdata = paddr[2] ? seed_q : {30'd0, terrain_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			terrain_q <= '0;
			seed_q    <= '0;
		end else if (psel && penable && pwrite) begin
			if (paddr[2]) begin
				seed_q <= pwdata;
			end else begin
				terrain_q <= pwdata[1:0];
			end
		end
	end

	// The front end classifies each word (start or byte, length in range)
	// and buffers it; the back end walks the stream format and drives results.
	esv_front #(
		.MAX_STREAM_BYTES(MAX_STREAM_BYTES)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.q_valid (q_valid),
		.q_item  (q_item),
		.q_pop   (q_pop)
	);

	esv_back #(
		.MAX_STREAM_BYTES(MAX_STREAM_BYTES)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.q_valid         (q_valid),
		.q_item          (q_item),
		.q_pop           (q_pop),
		.expected_terrain(terrain_q),
		.expected_seed   (seed_q),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.m_tdata         (m_tdata),
		.m_tuser         (m_tuser)
	);

endmodule

/* tb/sv/edit_save_stream_checker.sv */
`timescale 1ns / 1ps

module edit_save_stream_checker import esv_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [39:0]  s_tdata,
	input  logic         s_tuser,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [135:0] m_tdata,
	input  logic         m_tuser,
	output int           fail_count,
	output int           pending
);

	typedef enum logic [1:0] {PH_IDLE, PH_HEADER, PH_EDITS, PH_CHECK} phase_t;

	typedef struct {
		kind_t       kind;
		logic [31:0] crd [4];
		logic        solid;
		logic [3:0]  status;
	} result_t;

	localparam logic [63:0] FnvPrime = 64'd1099511628211;
	localparam logic [63:0] CountLimit = (64'(MaxStreamBytes) - FixedBytes) / EditBytes;
	localparam logic [7:0] Sig [8] = '{8'h50, 8'h52, 8'h4F, 8'h4A, 8'h34, 8'h44, 8'h57, 8'h53};

	logic [1:0]  world_terrain;
	logic [31:0] world_seed;
	phase_t      ph;
	logic [31:0] pos, stream_len, ver, ter, seed, edits_left;
	logic [63:0] hash, shreg;
	logic [31:0] cur [4];
	logic [31:0] prev [4];
	logic        prev_ok;
	result_t     expected_results [$];

	assign pending = expected_results.size();

	function automatic result_t status_result(logic [3:0] code);
		result_t r;
		r.kind = KIND_STATUS;
		for (int i = 0; i < 4; i++) r.crd[i] = '0;
		r.solid = 1'b0;
		r.status = code;
		return r;
	endfunction

	function automatic bit ordered_after_prev();
		for (int i = 0; i < 4; i++) begin
			if ($signed(prev[i]) < $signed(cur[i])) return 1;
			if ($signed(prev[i]) > $signed(cur[i])) return 0;
		end
		return 0;
	endfunction

	task automatic fail_status(logic [3:0] code);
		expected_results = {expected_results, status_result(code)};
		ph = PH_IDLE;
	endtask

	// Advances the stream state by one accepted word.
	task automatic validate_word(logic is_byte, logic [31:0] len, logic [7:0] b);
		result_t r;
		logic [31:0] p;
		if (!is_byte) begin
			hash = FnvBasis;
			pos = 0; shreg = 0; ver = 0; ter = 0; seed = 0; edits_left = 0;
			prev_ok = 0;
			stream_len = len;
			if (len < FixedBytes || len > MaxStreamBytes) fail_status(ST_SIZE);
			else ph = PH_HEADER;
			return;
		end
		if (ph == PH_IDLE) return;
		if (ph == PH_CHECK) begin
			shreg |= 64'(b) << (8 * pos[2:0]);
			pos++;
			if (pos >= 8) fail_status(shreg == hash ? ST_OK : ST_CHECKSUM);
			return;
		end
		hash = (hash ^ 64'(b)) * FnvPrime;
		p = pos;
		if (ph == PH_HEADER) begin
			if (p < 8) begin
				if (b != Sig[p]) begin
					fail_status(ST_SIGNATURE);
					return;
				end
			end else if (p < 12) ver |= 32'(b) << (8 * (p - 8));
			else if (p < 16) ter |= 32'(b) << (8 * (p - 12));
			else if (p < 20) seed |= 32'(b) << (8 * (p - 16));
			else shreg |= 64'(b) << (8 * (p - 20));
			pos = p + 1;
			if (p != 27) return;
			if (ver != FormatVersion) fail_status(ST_VERSION);
			else if (ter != 32'(world_terrain) || seed != world_seed) fail_status(ST_WORLD);
			else if (shreg > CountLimit || 64'(stream_len) != FixedBytes + shreg * EditBytes)
				fail_status(ST_COUNT);
			else begin
				edits_left = shreg[31:0];
				pos = 0;
				shreg = 0;
				ph = (edits_left != 0) ? PH_EDITS : PH_CHECK;
			end
			return;
		end
		if (p == 0) for (int i = 0; i < 4; i++) cur[i] = 0;
		if (p < 16) begin
			cur[p[3:2]] |= 32'(b) << (8 * p[1:0]);
			pos = p + 1;
			return;
		end
		if (b > 1) begin
			fail_status(ST_BLOCK);
			return;
		end
		if (prev_ok && !ordered_after_prev()) begin
			fail_status(ST_ORDER);
			return;
		end
		r.kind = KIND_EDIT;
		for (int i = 0; i < 4; i++) begin
			prev[i] = cur[i];
			r.crd[i] = cur[i];
		end
		r.solid = b[0];
		r.status = ST_OK;
		expected_results = {expected_results, r};
		prev_ok = 1;
		pos = 0;
		edits_left--;
		if (edits_left == 0) begin
			ph = PH_CHECK;
			shreg = 0;
		end
	endtask

	task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected %0h, actual %0h", name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t r;
		if (!arst_n) begin
			world_terrain = 0; world_seed = 0; ph = PH_IDLE;
			pos = 0; stream_len = 0; hash = FnvBasis; shreg = 0;
			ver = 0; ter = 0; seed = 0; edits_left = 0; prev_ok = 0;
			for (int i = 0; i < 4; i++) begin
				cur[i] = 0;
				prev[i] = 0;
			end
			expected_results.delete();
			fail_count = 0;
		end else begin
			// The output is checked first; a word accepted now cannot emerge in this cycle.
			if (m_tvalid && m_tready) begin
				if (expected_results.size() == 0) begin
					$error("result word with nothing expected");
					fail_count++;
				end else begin
					r = expected_results.pop_front();
					compare_field("kind", 32'(r.kind), 32'(m_tuser));
					compare_field("coord_x", r.crd[0], m_tdata[31:0]);
					compare_field("coord_y", r.crd[1], m_tdata[63:32]);
					compare_field("coord_z", r.crd[2], m_tdata[95:64]);
					compare_field("coord_w", r.crd[3], m_tdata[127:96]);
					compare_field("solid", 32'(r.solid), 32'(m_tdata[128]));
					compare_field("status", 32'(r.status), 32'(m_tdata[132:129]));
				end
			end
			if (psel && penable && pwrite) begin
				if (paddr == 3'd0) world_terrain = pwdata[1:0];
				else if (paddr == 3'd4) world_seed = pwdata;
			end
			if (s_tvalid && s_tready)
				validate_word(s_tuser, s_tdata[31:0], s_tdata[39:32]);
		end
	end

endmodule

/* tb/sv/edit_save_stream_validator_tb.sv */
`timescale 1ns / 1ps

module edit_save_stream_validator_tb;
	import esv_pkg::*;

	localparam int StallLimit = 20000;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [2:0]   paddr = '0;
	logic [31:0]  pwdata = '0;
	logic [31:0]  prdata;
	logic         pready;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [39:0]  s_tdata = '0;  // stream_length[31:0], data_byte[39:32]
	logic         s_tuser = 1'b0;  // opcode
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [135:0] m_tdata;  // coord_x, coord_y, coord_z, coord_w, solid, status, pad
	logic         m_tuser;  // kind
	int           fail_count, pending;
	int           idle_cycles = 0;
	bit           stim_done = 0;

	// Shadow of the world registers, used to build streams that pass the world check.
	logic [1:0]  cfg_terrain = 0;
	logic [31:0] cfg_seed = 0;

	always #6 clk = ~clk;

	edit_save_stream_validator dut (.*);

	edit_save_stream_checker checker_i (.*);

	// Random gap lengths: mostly none or short, occasionally long.
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 93) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// The receiver stalls on its own schedule, with gaps on every phase of the work.
	initial begin
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			m_tready <= 1'b1;
			repeat ($urandom_range(1, 30)) @(negedge clk);
			if (gap_len() > 0) begin
				m_tready <= 1'b0;
				repeat (gap_len() + 1) @(negedge clk);
			end
		end
	end

	// Watchdog: the run ends if no word moves on either side for too long.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !arst_n) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= StallLimit) begin
			$display("status: fail");
			$finish;
		end
	end

	// Sends one word and holds it until the block takes it, sometimes after a gap.
	task automatic send_word(opcode_t op, logic [31:0] len, logic [7:0] b);
		int g;
		g = gap_len();
		if (g > 0) begin
			s_tvalid <= 1'b0;
			repeat (g) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {b, len};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_start(logic [31:0] len);
		send_word(OP_START, len, 8'($urandom()));
	endtask

	task automatic send_byte(logic [7:0] b);
		send_word(OP_BYTE, $urandom(), b);
	endtask

	task automatic apb_write(logic [2:0] addr, logic [31:0] data);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
	endtask

	// Waits until every expected result has left, then lets the pipeline settle.
	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic set_world(logic [1:0] ter, logic [31:0] seed);
		drain();
		apb_write(3'd0, 32'(ter));
		apb_write(3'd4, seed);
		cfg_terrain = ter;
		cfg_seed = seed;
	endtask

	// Sends one save stream of n edits. The fault argument breaks one part of it:
	// 0 none, 1 signature, 2 version, 3 world, 4 count, 5 block value, 6 order,
	// 7 checksum, 8 cut short by a new start.
	task automatic send_stream(int n, int fault, logic [31:0] base, logic [31:0] spread);
		logic [7:0]  bytes [$];
		logic [63:0] h;
		logic [31:0] c [4];
		int bad_edit, bad_sig;
		bytes = {8'h50, 8'h52, 8'h4F, 8'h4A, 8'h34, 8'h44, 8'h57, 8'h53};
		for (int i = 0; i < 4; i++) bytes = {bytes, (i == 0 ? 8'd1 : 8'd0)};
		for (int i = 0; i < 4; i++) bytes = {bytes, 8'(32'(cfg_terrain) >> (8 * i))};
		for (int i = 0; i < 4; i++) bytes = {bytes, cfg_seed[8 * i +: 8]};
		for (int i = 0; i < 8; i++) bytes = {bytes, 8'((64'(n)) >> (8 * i))};
		for (int i = 0; i < 4; i++) c[i] = base + $urandom_range(0, spread);
		bad_edit = (n > 0) ? $urandom_range(0, n - 1) : 0;
		for (int e = 0; e < n; e++) begin
			// Advance one coordinate and randomize those after it; with a wide spread the sum can wrap.
			if (e > 0) begin
				int k;
				k = $urandom_range(0, 3);
				c[k] = c[k] + 1 + $urandom_range(0, spread);
				for (int i = k + 1; i < 4; i++) c[i] = base + $urandom_range(0, spread);
			end
			if (fault == 6 && e == bad_edit && e > 0) for (int i = 0; i < 4; i++) c[i] = c[i];
			for (int i = 0; i < 4; i++)
				for (int j = 0; j < 4; j++) bytes = {bytes, c[i][8 * j +: 8]};
			bytes = {bytes, ((fault == 5 && e == bad_edit) ? 8'($urandom_range(2, 255))
				: 8'($urandom_range(0, 1)))};
			if (fault == 6 && e == bad_edit && e > 0) begin
				// Repeat the edit just sent, which is not strictly greater.
				for (int i = 0; i < 17; i++) bytes = {bytes, bytes[bytes.size() - 17]};
			end
		end
		if (fault == 6 && n > 1) begin
			// Drop the last edit so the length still matches when one edit was duplicated.
			for (int i = 0; i < 17; i++) void'(bytes.pop_back());
		end
		h = FnvBasis;
		foreach (bytes[i]) h = (h ^ 64'(bytes[i])) * 64'd1099511628211;
		for (int i = 0; i < 8; i++) bytes = {bytes, h[8 * i +: 8]};
		case (fault)
			1: begin
				bad_sig = $urandom_range(0, 7);
				bytes[bad_sig] = bytes[bad_sig] ^ 8'($urandom_range(1, 255));
			end
			2: bytes[8 + $urandom_range(0, 3)] ^= 8'($urandom_range(1, 255));
			3: bytes[12 + $urandom_range(0, 7)] ^= 8'($urandom_range(1, 255));
			4: bytes[20 + $urandom_range(0, 7)] ^= 8'($urandom_range(1, 255));
			7: bytes[bytes.size() - 1 - $urandom_range(0, 7)] ^= 8'($urandom_range(1, 255));
			default: ;
		endcase
		send_start(FixedBytes + EditBytes * n);
		if (fault == 8) begin
			repeat ($urandom_range(0, bytes.size() - 1)) send_byte(bytes.pop_front());
			return;
		end
		foreach (bytes[i]) send_byte(bytes[i]);
		// Trailing bytes after the final status are ignored.
		if ($urandom_range(0, 9) == 0) send_byte(8'($urandom()));
	endtask

	initial begin
		int words;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed part: bad lengths, bytes while idle and each failing check.
		send_byte(8'hFF);
		send_start(32'd0);
		send_start(32'd35);
		send_start(32'hFFFF_FFFF);
		send_start(MaxStreamBytes + 1);
		send_start(MaxStreamBytes);
		send_byte(8'h00);
		send_stream(0, 0, 32'h0, 32'h0);
		send_stream(2, 0, 32'h8000_0000, 32'h7FFF_FFFF);
		send_stream(2, 0, 32'h7FFF_FFF0, 32'h0);
		for (int f = 1; f <= 8; f++) send_stream(3, f, 32'hFFFF_FFF8, 32'h4);
		set_world(2'd3, 32'hFFFF_FFFF);
		send_stream(1, 0, 32'h0, 32'hFFFF_FFFF);
		send_stream(1, 3, 32'h0, 32'hF);
		set_world(2'd2, 32'h0000_0000);
		send_stream(2, 0, 32'h0, 32'hFF);

		// Random part: mostly well-formed streams, some broken ones and some noise.
		// The directed part above already sends about a thousand words.
		words = 0;
		while (words < 720) begin
			int r, n;
			r = $urandom_range(0, 99);
			n = $urandom_range(0, 4);
			if (r < 3) begin
				set_world(2'($urandom_range(0, 3)), $urandom());
			end else if (r < 8) begin
				send_start($urandom_range(0, 1) ? $urandom() : $urandom_range(0, 60));
				words++;
			end else if (r < 12) begin
				send_byte(8'($urandom()));
				words++;
			end else begin
				send_stream(n, (r < 60) ? 0 : $urandom_range(1, 8),
					$urandom(), (r % 2) ? 32'h3 : 32'hFFFF_FFFF);
				words += FixedBytes + EditBytes * n;
			end
		end
		set_world(2'd0, 32'd0);
		stim_done = 1;
	end

	initial begin
		wait (stim_done);
		repeat (10) @(negedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

/* filelist.f */
rtl/esv_pkg.sv
rtl/esv_front.sv
rtl/esv_back.sv
rtl/edit_save_stream_validator.sv
tb/sv/edit_save_stream_checker.sv
tb/sv/edit_save_stream_validator_tb.sv
